>>> hdl/icaf_pkg.sv
// shared types, constants and helper functions of the attitude filter
`timescale 1ns / 1ps
package icaf_pkg;

  localparam int unsigned CAL_SAMPLES  = 100;
  localparam int unsigned CORDIC_STEPS = 20;
  // integration step of 0.01 s, rates are divided by this
  localparam int unsigned RATE_STEPS   = 100;

  localparam logic [12:0] CAL_DIVISOR  = 13'(CAL_SAMPLES);

  // reciprocal multiply constants: q = (n * magic) >> shift for any 32-bit n
  localparam int unsigned CAL_SHIFT  = 32 + $clog2(CAL_SAMPLES);
  localparam int unsigned RATE_SHIFT = 32 + $clog2(RATE_STEPS);
  localparam logic [32:0] CAL_MAGIC  =
    33'(((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic [32:0] RATE_MAGIC =
    33'(((64'd1 << RATE_SHIFT) + 64'(RATE_STEPS) - 64'd1) / 64'(RATE_STEPS));

  localparam logic signed [31:0] DEG360 = 32'sd23592960;
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  localparam logic [15:0] GAIN_RESET  = 16'd64225;
  localparam logic [23:0] SCALE_RESET = 24'd1167095;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GAIN  = 1'b0;
  localparam cfg_idx_t CFG_SCALE = 1'b1;

  typedef logic [2:0] mul_op_t;
  localparam mul_op_t MUL_NONE = 3'd0;
  localparam mul_op_t MUL_RATE = 3'd1;
  localparam mul_op_t MUL_OLD  = 3'd2;
  localparam mul_op_t MUL_NEW  = 3'd3;
  localparam mul_op_t MUL_YAW  = 3'd4;

  typedef logic [2:0] wr_op_t;
  localparam wr_op_t WR_NONE  = 3'd0;
  localparam wr_op_t WR_RATE  = 3'd1;
  localparam wr_op_t WR_INC   = 3'd2;
  localparam wr_op_t WR_BIAS  = 3'd3;
  localparam wr_op_t WR_ANG   = 3'd4;
  localparam wr_op_t WR_BLEND = 3'd5;
  localparam wr_op_t WR_YAW   = 3'd6;

  typedef struct packed {
    logic [15:0] gyro_x;
    logic [15:0] gyro_y;
    logic [15:0] gyro_z;
    logic [12:0] accel_x;
    logic [12:0] accel_y;
    logic [12:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] roll_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] yaw_angle;
    logic               ready_res;
  } out_item_t;

  typedef struct packed {
    logic       load;
    mul_op_t    mul_op;
    logic       acc_en;
    logic       acc_clr;
    wr_op_t     wr_op;
    logic [1:0] axis;
    logic       pitch;
    logic       div_start;
    logic       div_cal;
    logic       sqrt_start;
    logic       cordic_start;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic cal;
    logic seed;
    logic div_busy;
    logic sqrt_busy;
    logic cordic_busy;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SAT_MAX) return 32'sh7FFF_FFFF;
    if (v < SAT_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // round to nearest, ties up, then saturate
  function automatic logic signed [31:0] rnd_sat8(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd128) >>> 8;
    return sat32(t);
  endfunction

  function automatic logic signed [31:0] rnd_sat16(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd32768) >>> 16;
    return sat32(t);
  endfunction

endpackage

>>> hdl/icaf_isqrt.sv
// bit-serial floor square root of a radicand shifted up by 32 bits
`timescale 1ns / 1ps
module icaf_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        busy,
  output logic [31:0] root
);
  import icaf_pkg::*;

  logic [63:0] n_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [35:0] t;
  logic [35:0] trial;
  logic        ge;

  assign t     = {rem_r, n_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = (t >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd31;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  // two radicand bits per step, one root bit out
  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= {radicand, 32'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= {n_r[61:0], 2'b00};
      rem_r  <= ge ? 34'(t - trial) : t[33:0];
      root_r <= {root_r[30:0], ge};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

>>> hdl/icaf_cordic.sv
// vectoring cordic giving atan2 in q16.16 degrees, one micro-rotation per cycle
`timescale 1ns / 1ps
module icaf_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [39:0] y_in,
  input  logic signed [39:0] x_in,
  output logic               busy,
  output logic signed [31:0] z
);
  import icaf_pkg::*;

  logic signed [39:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [4:0]         step_r;
  logic               busy_r;
  logic signed [39:0] dx, dy;

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 5'd0;
    end else if (start) begin
      // zero vertical component settles at once with a zero angle
      busy_r <= (y_in != 40'sd0);
      step_r <= 5'd0;
    end else if (busy_r) begin
      if (step_r == 5'(CORDIC_STEPS - 1)) busy_r <= 1'b0;
      step_r <= step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_in;
      y_r <= y_in;
      z_r <= '0;
    end else if (busy_r) begin
      if (!y_r[39]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_deg(step_r);
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_deg(step_r);
      end
    end
  end

  assign busy = busy_r;
  assign z    = z_r;

endmodule

>>> hdl/icaf_dp.sv
// datapath: filter state, shared multiplier and accumulator, divider, root and angle units
`timescale 1ns / 1ps
module icaf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  icaf_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  icaf_pkg::cfg_idx_t   cfg_index,
  input  logic [23:0]          cfg_wdata,
  input  icaf_pkg::dp_cmd_t    cmd,
  output icaf_pkg::dp_sts_t    sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output icaf_pkg::out_item_t  out_data
);
  import icaf_pkg::*;

  logic [15:0]        gain_r;
  logic [23:0]        scale_r;
  logic signed [15:0] g_r [3];
  logic signed [12:0] ax_r, ay_r, az_r;
  logic [31:0]        sums_r [3];
  logic [12:0]        count_r;
  logic [12:0]        count_inc;
  logic signed [15:0] bias_r [3];
  logic signed [31:0] roll_r, pitch_r, yaw_r;
  logic               cal_r, seed_r;
  logic signed [31:0] rate_r [3];
  logic signed [31:0] inc_r [3];
  logic signed [31:0] ang_roll_r, ang_pitch_r;

  logic signed [16:0] rate_diff;
  logic signed [31:0] ang_sel, old_sel, inc_sel;
  logic [16:0]        gain_comp;
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] prod_nxt, prod_r;
  logic signed [63:0] mac_r;
  logic signed [31:0] yaw_sat, yaw_wrap;

  logic [31:0] div_src;
  logic [31:0] div_mag_r;
  logic        div_neg_r;
  logic        div_cal_r;
  logic        div_busy_r;
  logic [64:0] div_prod_r;
  logic [32:0] div_magic;
  logic [31:0] div_q;
  logic [31:0] div_res;

  logic [25:0]        ax2, ay2, az2;
  logic [31:0]        sq_roll, sq_pitch;
  logic               sqrt_busy;
  logic [31:0]        sqrt_root;
  logic signed [39:0] ax40, ay40, y_roll, y_pitch;
  logic               cordic_busy;
  logic signed [31:0] cordic_z;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      show_rates;

  assign count_inc = count_r + 13'd1;

  // multiplier operand selection
  assign rate_diff = 17'(g_r[cmd.axis]) - 17'(bias_r[cmd.axis]);
  assign ang_sel   = cmd.pitch ? ang_pitch_r : ang_roll_r;
  assign old_sel   = seed_r ? ang_sel : (cmd.pitch ? pitch_r : roll_r);
  assign inc_sel   = cmd.pitch ? inc_r[0] : inc_r[1];
  assign gain_comp = 17'h10000 - {1'b0, gain_r};

  always_comb begin
    unique case (cmd.mul_op)
      MUL_RATE: begin
        mul_a = 34'(rate_diff);
        mul_b = $signed({1'b0, scale_r});
      end
      MUL_OLD: begin
        mul_a = 34'(old_sel) + 34'(inc_sel);
        mul_b = $signed({9'b0, gain_r});
      end
      MUL_NEW: begin
        mul_a = 34'(ang_sel);
        mul_b = $signed({8'b0, gain_comp});
      end
      MUL_YAW: begin
        mul_a = 34'(yaw_r) + 34'(inc_r[2]);
        mul_b = $signed({9'b0, gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign yaw_sat  = rnd_sat16(mac_r);
  assign yaw_wrap = (yaw_sat > DEG360) ? yaw_sat - DEG360 : yaw_sat;

  // division by a constant via reciprocal multiply, on magnitudes, truncating
  assign div_src   = cmd.div_cal ? sums_r[cmd.axis] : rate_r[cmd.axis];
  assign div_magic = div_cal_r ? CAL_MAGIC : RATE_MAGIC;
  assign div_q     = div_cal_r ? 32'(div_prod_r >> CAL_SHIFT)
                               : 32'(div_prod_r >> RATE_SHIFT);
  assign div_res   = div_neg_r ? 32'(-div_q) : div_q;

  // radicands for the two accelerometer angles
  assign ax2      = 26'(ax_r * ax_r);
  assign ay2      = 26'(ay_r * ay_r);
  assign az2      = 26'(az_r * az_r);
  assign sq_roll  = 32'(ay2) + 32'(az2);
  assign sq_pitch = {az2, 6'b0} + 32'({az2, 5'b0}) + 32'({az2, 2'b0}) + 32'(ax2);

  assign ax40    = 40'(ax_r);
  assign ay40    = 40'(ay_r);
  assign y_roll  = (-ax40) <<< 16;
  assign y_pitch = ((ay40 <<< 3) + (ay40 <<< 1)) <<< 16;

  icaf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (cmd.pitch ? sq_pitch : sq_roll),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  icaf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cordic_start),
    .y_in  (cmd.pitch ? y_pitch : y_roll),
    .x_in  ($signed({8'b0, sqrt_root})),
    .busy  (cordic_busy),
    .z     (cordic_z)
  );

  // filter state, configuration and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      scale_r     <= SCALE_RESET;
      sums_r      <= '{default: '0};
      bias_r      <= '{default: '0};
      count_r     <= '0;
      roll_r      <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
      cal_r       <= 1'b0;
      seed_r      <= 1'b0;
      div_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GAIN) gain_r <= cfg_wdata[15:0];
        else                       scale_r <= cfg_wdata;
      end
      if (cmd.load && !cal_r) begin
        sums_r[0] <= sums_r[0] + {{16{in_data.gyro_x[15]}}, in_data.gyro_x};
        sums_r[1] <= sums_r[1] + {{16{in_data.gyro_y[15]}}, in_data.gyro_y};
        sums_r[2] <= sums_r[2] + {{16{in_data.gyro_z[15]}}, in_data.gyro_z};
        if (count_inc == CAL_DIVISOR) begin
          count_r <= '0;
          seed_r  <= 1'b1;
        end else begin
          count_r <= count_inc;
        end
      end
      unique case (cmd.wr_op)
        WR_BIAS: begin
          bias_r[cmd.axis] <= div_res[15:0];
          sums_r[cmd.axis] <= '0;
        end
        WR_BLEND: begin
          if (cmd.pitch) pitch_r <= rnd_sat16(mac_r);
          else           roll_r  <= rnd_sat16(mac_r);
        end
        WR_YAW:  yaw_r <= yaw_wrap;
        default: ;
      endcase
      // the product is registered while div_busy_r is high, the quotient is ready the cycle after
      div_busy_r <= cmd.div_start;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (seed_r) begin
          cal_r  <= 1'b1;
          seed_r <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign show_rates = cal_r && !seed_r;

  // operands, intermediates and result beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      g_r[0] <= in_data.gyro_x;
      g_r[1] <= in_data.gyro_y;
      g_r[2] <= in_data.gyro_z;
      ax_r   <= in_data.accel_x;
      ay_r   <= in_data.accel_y;
      az_r   <= in_data.accel_z;
    end
    prod_r <= prod_nxt;
    if (cmd.acc_en) mac_r <= (cmd.acc_clr ? 64'sd0 : mac_r) + 64'(prod_r);
    unique case (cmd.wr_op)
      WR_RATE: rate_r[cmd.axis] <= rnd_sat8(mac_r);
      WR_INC:  inc_r[cmd.axis]  <= div_res;
      WR_ANG: begin
        if (cmd.pitch) ang_pitch_r <= cordic_z;
        else           ang_roll_r  <= cordic_z;
      end
      default: ;
    endcase
    if (cmd.div_start) begin
      div_neg_r <= div_src[31];
      div_mag_r <= div_src[31] ? 32'(-div_src) : div_src;
      div_cal_r <= cmd.div_cal;
    end
    if (div_busy_r) div_prod_r <= 65'(div_mag_r) * 65'(div_magic);
    if (cmd.finish) begin
      out_data_r.rate_x      <= show_rates ? rate_r[0] : 32'sd0;
      out_data_r.rate_y      <= show_rates ? rate_r[1] : 32'sd0;
      out_data_r.rate_z      <= show_rates ? rate_r[2] : 32'sd0;
      out_data_r.roll_angle  <= roll_r;
      out_data_r.pitch_angle <= pitch_r;
      out_data_r.yaw_angle   <= yaw_r;
      out_data_r.ready_res   <= cal_r | seed_r;
    end
  end

  assign sts.cal         = cal_r;
  assign sts.seed        = seed_r;
  assign sts.div_busy    = div_busy_r;
  assign sts.sqrt_busy   = sqrt_busy;
  assign sts.cordic_busy = cordic_busy;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result beat not presented after finish");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy_r)
    else $error("divider restarted while busy");

  a_seed_once: assert property (@(posedge clk) disable iff (!rst_n)
    seed_r |-> !cal_r)
    else $error("seed pending after calibration");

  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(cal_r))
    else $error("calibration flag dropped");

endmodule

>>> hdl/icaf_ctrl.sv
// sequencer that steps the datapath through calibration, rates, angles and blending
`timescale 1ns / 1ps
module icaf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  icaf_pkg::dp_sts_t sts,
  output icaf_pkg::dp_cmd_t cmd
);
  import icaf_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHECK  = 5'd1;
  localparam logic [4:0] S_BDIV   = 5'd2;
  localparam logic [4:0] S_BWAIT  = 5'd3;
  localparam logic [4:0] S_RMUL   = 5'd4;
  localparam logic [4:0] S_RACC   = 5'd5;
  localparam logic [4:0] S_RWR    = 5'd6;
  localparam logic [4:0] S_IDIV   = 5'd7;
  localparam logic [4:0] S_IWAIT  = 5'd8;
  localparam logic [4:0] S_QSTART = 5'd9;
  localparam logic [4:0] S_QWAIT  = 5'd10;
  localparam logic [4:0] S_CSTART = 5'd11;
  localparam logic [4:0] S_CWAIT  = 5'd12;
  localparam logic [4:0] S_BL1    = 5'd13;
  localparam logic [4:0] S_BL2    = 5'd14;
  localparam logic [4:0] S_BL3    = 5'd15;
  localparam logic [4:0] S_BL4    = 5'd16;
  localparam logic [4:0] S_YAW1   = 5'd17;
  localparam logic [4:0] S_YAW2   = 5'd18;
  localparam logic [4:0] S_YAW3   = 5'd19;
  localparam logic [4:0] S_FIN    = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       pitch_r, pitch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
      pitch_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    pitch_nxt = pitch_r;
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    cmd.wr_op  = WR_NONE;
    cmd.axis   = axis_r;
    cmd.pitch  = pitch_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        axis_nxt = '0;
        priority if (sts.seed) state_nxt = S_BDIV;
        else if (sts.cal)      state_nxt = S_RMUL;
        else                   state_nxt = S_FIN;
      end
      S_BDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_cal   = 1'b1;
        state_nxt     = S_BWAIT;
      end
      S_BWAIT: begin
        if (!sts.div_busy) begin
          cmd.wr_op = WR_BIAS;
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = S_RMUL;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_BDIV;
          end
        end
      end
      S_RMUL: begin
        cmd.mul_op = MUL_RATE;
        state_nxt  = S_RACC;
      end
      S_RACC: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_RWR;
      end
      S_RWR: begin
        cmd.wr_op = WR_RATE;
        state_nxt = S_IDIV;
      end
      S_IDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_IWAIT;
      end
      S_IWAIT: begin
        if (!sts.div_busy) begin
          cmd.wr_op = WR_INC;
          if (axis_r == 2'd2) begin
            pitch_nxt = 1'b0;
            state_nxt = S_QSTART;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_RMUL;
          end
        end
      end
      S_QSTART: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_QWAIT;
      end
      S_QWAIT: begin
        if (!sts.sqrt_busy) state_nxt = S_CSTART;
      end
      S_CSTART: begin
        cmd.cordic_start = 1'b1;
        state_nxt        = S_CWAIT;
      end
      S_CWAIT: begin
        if (!sts.cordic_busy) begin
          cmd.wr_op = WR_ANG;
          if (pitch_r) begin
            pitch_nxt = 1'b0;
            state_nxt = S_BL1;
          end else begin
            pitch_nxt = 1'b1;
            state_nxt = S_QSTART;
          end
        end
      end
      S_BL1: begin
        cmd.mul_op = MUL_OLD;
        state_nxt  = S_BL2;
      end
      S_BL2: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.mul_op  = MUL_NEW;
        state_nxt   = S_BL3;
      end
      S_BL3: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_BL4;
      end
      S_BL4: begin
        cmd.wr_op = WR_BLEND;
        if (pitch_r) begin
          state_nxt = sts.seed ? S_FIN : S_YAW1;
        end else begin
          pitch_nxt = 1'b1;
          state_nxt = S_BL1;
        end
      end
      S_YAW1: begin
        cmd.mul_op = MUL_YAW;
        state_nxt  = S_YAW2;
      end
      S_YAW2: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_YAW3;
      end
      S_YAW3: begin
        cmd.wr_op = WR_YAW;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> hdl/imu_complementary_attitude_filter.sv
// top level of the imu complementary attitude filter
`timescale 1ns / 1ps
// usage
// - input channel: one imu sample per beat (three gyro axes, three accel axes),
//   taken when in_valid is high and in_stall is low
// - result channel: one beat per sample with rates, roll, pitch, yaw and the
//   ready flag, held in an output register until out_stall is low
// - cfg port: cfg_we writes blend gain (index 0) or gyro scale (index 1) at once;
//   write only while the block is idle
// - the first 100 samples calibrate the gyro bias; each is only summed per gyro
//   axis before its result beat is presented
// - a calibrated sample runs three rate passes (multiply, round, divide by 100
//   through a reciprocal multiply), two 32-step square roots and two 20-step
//   cordic runs done one after another, the blend steps for roll and pitch
//   and the yaw update; a zero vertical component skips its cordic run
// - the last calibration sample runs three bias divisions plus the seeding
//   pass without the yaw update
// - the next sample is taken while a finished result still waits on out_stall;
//   a stalled result only holds the sequencer at its last step
// - reset (rst_n low, synchronous) restores register defaults, clears the
//   calibration sums, bias and angle state and drops out_valid
module imu_complementary_attitude_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  icaf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output icaf_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  icaf_pkg::cfg_idx_t   cfg_index,
  input  logic [23:0]          cfg_wdata
);
  import icaf_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  icaf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  icaf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
